### design/bblc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// bblc_pkg
// Shared types and constants for the byte-budget LRU cache directory.
// ============================================================================
package bblc_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int KEY_W       = 32;
    localparam int LEN_W       = 24;
    localparam int KIND_W      = 2;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [KIND_W-1:0] KIND_HIT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EVICT  = 2'd3;

    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_EVICT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_HIT,
        OP_REJECT,
        OP_EVICT,
        OP_INSERT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic len_ok;
        logic fits;
        logic out_free;
    } stat_t;

endpackage

### design/byte_budget_lru_cache_directory_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// byte_budget_lru_cache_directory_unit
// LRU directory of flash objects under a byte budget, with an APB-style
// register for the budget.
// ============================================================================
// One request is handled at a time. A hit or a reject goes from the lookup
// state to the output register once that register is free; a miss runs an
// eviction walk that emits one notice per cycle, while the consumer takes
// each, through the single result register before the insert result. The
// next request is taken the cycle after the final result is loaded, while
// that result may still wait for the consumer. Lookup compares all stored
// keys at once. No clearing pass follows reset.
module byte_budget_lru_cache_directory_unit
#(
    parameter  int ENTRIES = bblc_pkg::ENTRIES_DEF,
    localparam int SLOT_W  = $clog2(ENTRIES)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bblc_pkg::ADDR_W-1:0]  paddr,
    input  logic [bblc_pkg::DATA_W-1:0]  pwdata,
    output logic [bblc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [bblc_pkg::KEY_W-1:0]   key,
    input  logic [bblc_pkg::LEN_W-1:0]   length,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bblc_pkg::KIND_W-1:0]  result_kind,
    output logic [SLOT_W-1:0]            slot,
    output logic [bblc_pkg::KEY_W-1:0]   entry_key,
    output logic [bblc_pkg::LEN_W-1:0]   entry_length,
    output logic                         last
);
    import bblc_pkg::*;

    logic [LEN_W-1:0] cap_reg;
    logic [LEN_W-1:0] cap_next;
    logic             cap_sel;
    cmd_t             cmd;
    stat_t            stat;

    assign pready  = 1'b1;
    assign cap_sel = (paddr[ADDR_W-1] == REG_CAPACITY);

    always_comb
    begin
        cap_next = cap_reg;
        if (psel && penable && pwrite && pready && cap_sel)
        begin
            cap_next = pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= '0;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    assign prdata = cap_sel ? {{(DATA_W - LEN_W){1'b0}}, cap_reg} : '0;

    bblc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bblc_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .key          (key),
        .length       (length),
        .capacity     (cap_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .slot         (slot),
        .entry_key    (entry_key),
        .entry_length (entry_length),
        .last         (last)
    );

endmodule

### design/bblc_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// bblc_ctrl
// Request sequencer: accepts a request, decides hit, reject or miss, and
// steps through evictions and the final insert one result at a time.
// ============================================================================
module bblc_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  bblc_pkg::stat_t stat,
    output bblc_pkg::cmd_t  cmd
);
    import bblc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (!stat.hit && stat.len_ok)
                begin
                    state_next = S_EVICT;
                end
                else if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EVICT:
            begin
                if (stat.out_free && stat.fits)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            S_LOOKUP:
            begin
                if (stat.out_free)
                begin
                    if (stat.hit)
                    begin
                        cmd.op = OP_HIT;
                    end
                    else if (!stat.len_ok)
                    begin
                        cmd.op = OP_REJECT;
                    end
                end
            end
            S_EVICT:
            begin
                if (stat.out_free)
                begin
                    cmd.op = stat.fits ? OP_INSERT : OP_EVICT;
                end
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

### design/bblc_dpath.sv
`timescale 1ns / 1ps
// ============================================================================
// bblc_dpath
// Directory storage, associative lookup, recency ranks, byte accounting and
// the registered result stage.
// ============================================================================
module bblc_dpath
#(
    parameter  int ENTRIES = bblc_pkg::ENTRIES_DEF,
    localparam int SLOT_W  = $clog2(ENTRIES)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  bblc_pkg::cmd_t               cmd,
    output bblc_pkg::stat_t              stat,
    input  logic [bblc_pkg::KEY_W-1:0]   key,
    input  logic [bblc_pkg::LEN_W-1:0]   length,
    input  logic [bblc_pkg::LEN_W-1:0]   capacity,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bblc_pkg::KIND_W-1:0]  result_kind,
    output logic [SLOT_W-1:0]            slot,
    output logic [bblc_pkg::KEY_W-1:0]   entry_key,
    output logic [bblc_pkg::LEN_W-1:0]   entry_length,
    output logic                         last
);
    import bblc_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [SLOT_W-1:0]  rank_reg [ENTRIES];
    logic [SLOT_W-1:0]  rank_next [ENTRIES];
    logic [KEY_W-1:0]   skey_reg [ENTRIES];
    logic [KEY_W-1:0]   skey_next [ENTRIES];
    logic [LEN_W-1:0]   slen_reg [ENTRIES];
    logic [LEN_W-1:0]   slen_next [ENTRIES];
    logic [LEN_W-1:0]   bytes_reg;
    logic [LEN_W-1:0]   bytes_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [KEY_W-1:0]   req_key_reg;
    logic [KEY_W-1:0]   req_key_next;
    logic [LEN_W-1:0]   req_len_reg;
    logic [LEN_W-1:0]   req_len_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [KIND_W-1:0]  kind_reg;
    logic [KIND_W-1:0]  kind_next;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;
    logic [KEY_W-1:0]   ekey_reg;
    logic [KEY_W-1:0]   ekey_next;
    logic [LEN_W-1:0]   elen_reg;
    logic [LEN_W-1:0]   elen_next;
    logic               last_reg;
    logic               last_next;

    logic               hit_found;
    logic [SLOT_W-1:0]  hit_slot;
    logic [SLOT_W-1:0]  victim_slot;
    logic [SLOT_W-1:0]  free_slot;
    logic [SLOT_W-1:0]  lru_rank;
    logic [SLOT_W-1:0]  hit_rank;
    logic [LEN_W:0]     bytes_sum;

    assign lru_rank = SLOT_W'(count_reg - CNT_W'(1));

    // The valid ranks always form a permutation of 0..count-1, so the least
    // recently used entry is the one that holds rank count-1.
    always_comb
    begin
        hit_found   = 1'b0;
        hit_slot    = '0;
        victim_slot = '0;
        free_slot   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && skey_reg[i] == req_key_reg)
            begin
                hit_found = 1'b1;
                hit_slot  = SLOT_W'(i);
            end
            if (valid_reg[i] && rank_reg[i] == lru_rank)
            begin
                victim_slot = SLOT_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    assign hit_rank  = rank_reg[hit_slot];
    assign bytes_sum = {1'b0, bytes_reg} + {1'b0, req_len_reg};

    assign stat.hit      = hit_found;
    assign stat.len_ok   = (req_len_reg != '0) && (req_len_reg <= capacity);
    assign stat.fits     = (count_reg == '0)
                         || ((bytes_sum <= {1'b0, capacity})
                             && (count_reg != CNT_W'(ENTRIES)));
    assign stat.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        valid_next     = valid_reg;
        rank_next      = rank_reg;
        skey_next      = skey_reg;
        slen_next      = slen_reg;
        bytes_next     = bytes_reg;
        count_next     = count_reg;
        req_key_next   = req_key_reg;
        req_len_next   = req_len_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        slot_next      = slot_reg;
        ekey_next      = ekey_reg;
        elen_next      = elen_reg;
        last_next      = last_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                req_key_next = key;
                req_len_next = length;
            end
            OP_HIT:
            begin
                for (int j = 0; j < ENTRIES; j++)
                begin
                    if (valid_reg[j] && rank_reg[j] < hit_rank)
                    begin
                        rank_next[j] = rank_reg[j] + SLOT_W'(1);
                    end
                end
                rank_next[hit_slot] = '0;
                out_valid_next      = 1'b1;
                kind_next           = KIND_HIT;
                slot_next           = hit_slot;
                ekey_next           = req_key_reg;
                elen_next           = req_len_reg;
                last_next           = 1'b1;
            end
            OP_REJECT:
            begin
                out_valid_next = 1'b1;
                kind_next      = KIND_REJECT;
                slot_next      = '0;
                ekey_next      = req_key_reg;
                elen_next      = req_len_reg;
                last_next      = 1'b1;
            end
            OP_EVICT:
            begin
                valid_next[victim_slot] = 1'b0;
                bytes_next              = bytes_reg - slen_reg[victim_slot];
                count_next              = count_reg - CNT_W'(1);
                out_valid_next          = 1'b1;
                kind_next               = KIND_EVICT;
                slot_next               = victim_slot;
                ekey_next               = skey_reg[victim_slot];
                elen_next               = slen_reg[victim_slot];
                last_next               = 1'b0;
            end
            OP_INSERT:
            begin
                for (int j = 0; j < ENTRIES; j++)
                begin
                    if (valid_reg[j])
                    begin
                        rank_next[j] = rank_reg[j] + SLOT_W'(1);
                    end
                end
                rank_next[free_slot]  = '0;
                valid_next[free_slot] = 1'b1;
                skey_next[free_slot]  = req_key_reg;
                slen_next[free_slot]  = req_len_reg;
                bytes_next            = bytes_sum[LEN_W-1:0];
                count_next            = count_reg + CNT_W'(1);
                out_valid_next        = 1'b1;
                kind_next             = KIND_INSERT;
                slot_next             = free_slot;
                ekey_next             = req_key_reg;
                elen_next             = req_len_reg;
                last_next             = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            bytes_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg     <= valid_next;
            bytes_reg     <= bytes_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            rank_reg      <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        skey_reg    <= skey_next;
        slen_reg    <= slen_next;
        req_key_reg <= req_key_next;
        req_len_reg <= req_len_next;
        kind_reg    <= kind_next;
        slot_reg    <= slot_next;
        ekey_reg    <= ekey_next;
        elen_reg    <= elen_next;
        last_reg    <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign slot         = slot_reg;
    assign entry_key    = ekey_reg;
    assign entry_length = elen_reg;
    assign last         = last_reg;

endmodule

### design/bblc_chk.sv
`timescale 1ns / 1ps
// ============================================================================
// bblc_chk
// Port-level checks for the cache directory, bound to the top level.
// ============================================================================
module bblc_chk
#(
    parameter  int ENTRIES = bblc_pkg::ENTRIES_DEF,
    localparam int SLOT_W  = $clog2(ENTRIES)
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [bblc_pkg::KIND_W-1:0]  result_kind,
    input logic [SLOT_W-1:0]            slot,
    input logic [bblc_pkg::KEY_W-1:0]   entry_key,
    input logic [bblc_pkg::LEN_W-1:0]   entry_length,
    input logic                         last
);
    import bblc_pkg::*;

    // A stalled result transfer keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind)
            && $stable(slot) && $stable(entry_key) && $stable(entry_length)
            && $stable(last))
        else $error("result changed while stalled");

    // Only one request is in work at a time.
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in work");

    a_evict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_EVICT |-> !last)
        else $error("eviction notice marked as final");

    a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_REJECT |-> last && slot == '0)
        else $error("malformed reject result");

endmodule

bind byte_budget_lru_cache_directory_unit bblc_chk #(.ENTRIES(ENTRIES)) u_bblc_chk (.*);
